### rtl/cfd_pkg.sv
package cfd_pkg;

    localparam int BYTE_W = 8;
    localparam int SUM_W = 16;
    localparam int STATUS_W = 2;
    localparam int DATA_LEN_W = 6;
    localparam int CFG_INDEX_W = 8;

    localparam int FRAME_CAPACITY_DEFAULT = 64;
    localparam int MIN_FRAME = 7;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SUM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SOF_BYTE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EOF_BYTE = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_FUNCTION = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION_FUNCTION = 8'd3;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] SOF_BYTE_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] EOF_BYTE_RESET = 8'h55;
    localparam logic [BYTE_W-1:0] SPEED_FUNCTION_RESET = 8'h01;
    localparam logic [BYTE_W-1:0] DIRECTION_FUNCTION_RESET = 8'h02;

    typedef struct packed {
        logic [BYTE_W-1:0] sof_byte;
        logic [BYTE_W-1:0] eof_byte;
        logic [BYTE_W-1:0] speed_function;
        logic [BYTE_W-1:0] direction_function;
    } cfd_cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [BYTE_W-1:0]     frame_type;
        logic [BYTE_W-1:0]     device_addr;
        logic [BYTE_W-1:0]     function_code;
        logic [DATA_LEN_W-1:0] data_length;
        logic [BYTE_W-1:0]     speed;
        logic [SUM_W-1:0]      degree;
    } cfd_result_t;

endpackage

### rtl/cfd_byte_if.sv
interface cfd_byte_if;
    import cfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);

endinterface

### rtl/cfd_frame_if.sv
interface cfd_frame_if;
    import cfd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [BYTE_W-1:0]     frame_type;
    logic [BYTE_W-1:0]     device_addr;
    logic [BYTE_W-1:0]     function_code;
    logic [DATA_LEN_W-1:0] data_length;
    logic [BYTE_W-1:0]     speed;
    logic [SUM_W-1:0]      degree;

    modport source (
        output valid, output status, output frame_type, output device_addr,
        output function_code, output data_length, output speed, output degree,
        input ready
    );
    modport sink (
        input valid, input status, input frame_type, input device_addr,
        input function_code, input data_length, input speed, input degree,
        output ready
    );

endinterface

### rtl/cfd_cfg_if.sv
interface cfd_cfg_if;
    import cfd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [BYTE_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

### rtl/cfd_core.sv
module cfd_core #(
    parameter int FRAME_CAPACITY = cfd_pkg::FRAME_CAPACITY_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [cfd_pkg::BYTE_W-1:0] rx_byte,
    input  cfd_pkg::cfd_cfg_t         cfg,
    output logic                      emit,
    output cfd_pkg::cfd_result_t      result
);
    import cfd_pkg::*;

    localparam int IDX_W = $clog2(FRAME_CAPACITY);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(FRAME_CAPACITY - 1);
    localparam logic [IDX_W-1:0] SHORT_LIMIT = IDX_W'(MIN_FRAME - 1);
    localparam logic [IDX_W-1:0] POS_TYPE = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_ADDR = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_FUNCTION = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_DATA_FIRST = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_DATA_SECOND = IDX_W'(5);

    logic              in_frame_reg, in_frame_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0] older_reg, older_next;
    logic [BYTE_W-1:0] newer_reg, newer_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic [BYTE_W-1:0] addr_reg, addr_next;
    logic [BYTE_W-1:0] func_reg, func_next;
    logic [BYTE_W-1:0] first_reg, first_next;
    logic [BYTE_W-1:0] second_reg, second_next;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]  len_off;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        idx_next = idx_reg;
        sum_next = sum_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        type_next = type_reg;
        addr_next = addr_reg;
        func_next = func_reg;
        first_next = first_reg;
        second_next = second_reg;
        emit = 1'b0;
        status = ST_OK;

        if (step)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == cfg.sof_byte)
                begin
                    // open a frame with clean capture and checksum state
                    in_frame_next = 1'b1;
                    idx_next = POS_TYPE;
                    sum_next = '0;
                    older_next = '0;
                    newer_next = '0;
                    type_next = '0;
                    addr_next = '0;
                    func_next = '0;
                    first_next = '0;
                    second_next = '0;
                    if (rx_byte == cfg.eof_byte)
                    begin
                        emit = 1'b1;
                        status = ST_SHORT;
                        in_frame_next = 1'b0;
                        idx_next = '0;
                    end
                end
            end
            else if (rx_byte == cfg.eof_byte)
            begin
                emit = 1'b1;
                in_frame_next = 1'b0;
                idx_next = '0;
                if (idx_reg < SHORT_LIMIT)
                begin
                    status = ST_SHORT;
                end
                else if ({older_reg, newer_reg} == sum_reg)
                begin
                    status = ST_OK;
                end
                else
                begin
                    status = ST_SUM;
                end
            end
            else
            begin
                // the byte two places back is known not to be checksum: add it
                sum_next = sum_reg + SUM_W'(older_reg);
                older_next = newer_reg;
                newer_next = rx_byte;
                if (idx_reg == POS_TYPE)
                begin
                    type_next = rx_byte;
                end
                else if (idx_reg == POS_ADDR)
                begin
                    addr_next = rx_byte;
                end
                else if (idx_reg == POS_FUNCTION)
                begin
                    func_next = rx_byte;
                end
                else if (idx_reg == POS_DATA_FIRST)
                begin
                    first_next = rx_byte;
                end
                else if (idx_reg == POS_DATA_SECOND)
                begin
                    second_next = rx_byte;
                end
                if (idx_reg >= LAST_POS)
                begin
                    emit = 1'b1;
                    status = ST_OVER;
                    in_frame_next = 1'b0;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    assign len_off = idx_reg - SHORT_LIMIT;

    always_comb
    begin
        result.status = status;
        result.frame_type = type_next;
        result.device_addr = addr_next;
        result.function_code = func_next;
        result.data_length = '0;
        result.speed = '0;
        result.degree = '0;
        if (status == ST_OK || status == ST_SUM)
        begin
            result.data_length = DATA_LEN_W'(len_off);
        end
        if (status == ST_OK && func_next == cfg.speed_function)
        begin
            result.speed = first_next;
        end
        if (status == ST_OK && func_next == cfg.direction_function)
        begin
            result.degree = {first_next, second_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            idx_reg <= '0;
            sum_reg <= '0;
            older_reg <= '0;
            newer_reg <= '0;
            type_reg <= '0;
            addr_reg <= '0;
            func_reg <= '0;
            first_reg <= '0;
            second_reg <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            idx_reg <= idx_next;
            sum_reg <= sum_next;
            older_reg <= older_next;
            newer_reg <= newer_next;
            type_reg <= type_next;
            addr_reg <= addr_next;
            func_reg <= func_next;
            first_reg <= first_next;
            second_reg <= second_next;
        end
    end

    a_emit_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> !in_frame_reg)
        else $error("frame still open after a result");

    a_hunt_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> idx_reg == '0)
        else $error("position counter nonzero while hunting");

    a_frame_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> idx_reg != '0)
        else $error("position counter zero inside a frame");

endmodule

### rtl/command_frame_deframer_unit.sv
// Command frame deframer.
//
// rx carries one received link byte per word. Bytes are dropped until the
// start code arrives; from then on every byte is part of the frame until the
// end code, or until the frame reaches FRAME_CAPACITY bytes. Each closed
// frame yields one word on frame: status, type, address, function, data
// length, and speed or degree when an ok frame's function code matches.
// cfg writes one of four registers (start code, end code, speed function,
// direction function) by index; writes to other indexes are dropped. Write
// only while no byte is in flight.
// An accepted rx word passes through the input register, then the frame
// logic, into the output register that drives the frame word.
// Throughput: one rx word per cycle while the output register is free or
// being taken; the frame logic between the two registers is single-pass.
// Reset clears frame state, empties both registers and loads the register
// defaults; the block starts hunting for a start code.
// When the frame receiver stalls, the output register holds its word, the
// input register fills, and rx.ready drops until the output moves.
module command_frame_deframer_unit #(
    parameter int FRAME_CAPACITY = cfd_pkg::FRAME_CAPACITY_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    cfd_byte_if.sink    rx,
    cfd_frame_if.source frame,
    cfd_cfg_if.sink     cfg
);
    import cfd_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    cfd_result_t       out_result_reg;
    cfd_cfg_t          cfg_reg;

    logic        advance;
    logic        step;
    logic        core_emit;
    cfd_result_t core_result;

    // The frame logic may run whenever the output register is free or emptying.
    assign advance = !out_valid_reg || frame.ready;
    assign step = in_valid_reg && advance;
    assign rx.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sof_byte <= SOF_BYTE_RESET;
            cfg_reg.eof_byte <= EOF_BYTE_RESET;
            cfg_reg.speed_function <= SPEED_FUNCTION_RESET;
            cfg_reg.direction_function <= DIRECTION_FUNCTION_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_SOF_BYTE:           cfg_reg.sof_byte <= cfg.data;
                REG_EOF_BYTE:           cfg_reg.eof_byte <= cfg.data;
                REG_SPEED_FUNCTION:     cfg_reg.speed_function <= cfg.data;
                REG_DIRECTION_FUNCTION: cfg_reg.direction_function <= cfg.data;
                default:                ;
            endcase
        end
    end

    cfd_core #(
        .FRAME_CAPACITY(FRAME_CAPACITY)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .emit    (core_emit),
        .result  (core_result)
    );

    // Output register: load a new result, or drop the old one once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && core_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && core_emit)
        begin
            out_result_reg <= core_result;
        end
    end

    assign frame.valid = out_valid_reg;
    assign frame.status = out_result_reg.status;
    assign frame.frame_type = out_result_reg.frame_type;
    assign frame.device_addr = out_result_reg.device_addr;
    assign frame.function_code = out_result_reg.function_code;
    assign frame.data_length = out_result_reg.data_length;
    assign frame.speed = out_result_reg.speed;
    assign frame.degree = out_result_reg.degree;

    a_taken_word_clears: assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && frame.ready && !(step && core_emit) |=> !frame.valid)
        else $error("delivered frame word repeated");

    a_blocked_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("rx word lost while output stalled");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        step && core_emit |=> frame.valid)
        else $error("frame result not presented");

endmodule

### test/command_frame_deframer_unit_test.sv
`timescale 1ns / 100ps

module command_frame_deframer_unit_test;
    import cfd_pkg::*;

    localparam int FRAME_CAPACITY = FRAME_CAPACITY_DEFAULT;
    // Longest stretch with no accepted word on any channel before giving up.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to let the two pipeline registers empty out after the last result.
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PAYLOAD = FRAME_CAPACITY - MIN_FRAME;
    // Index that maps to no register; the block must drop writes to it.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'hFF;
    localparam int FIRST_FREE_INDEX = 4;

    logic clk;
    logic rst_n;

    cfd_byte_if  rx_bus ();
    cfd_frame_if frame_bus ();
    cfd_cfg_if   cfg_bus ();

    command_frame_deframer_unit #(
        .FRAME_CAPACITY(FRAME_CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .rx(rx_bus),
        .frame(frame_bus),
        .cfg(cfg_bus)
    );

    // 2 ns period clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Deframer prediction: own copy of the registers and the frame state
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] cfg_start = SOF_BYTE_RESET;
    logic [BYTE_W-1:0] cfg_end = EOF_BYTE_RESET;
    logic [BYTE_W-1:0] cfg_speed_fn = SPEED_FUNCTION_RESET;
    logic [BYTE_W-1:0] cfg_dir_fn = DIRECTION_FUNCTION_RESET;

    bit                in_frame = 1'b0;
    int unsigned       next_pos = 0;
    logic [SUM_W-1:0]  sum_acc = '0;
    logic [BYTE_W-1:0] dly_old = '0;
    logic [BYTE_W-1:0] dly_new = '0;
    logic [BYTE_W-1:0] cap_type = '0;
    logic [BYTE_W-1:0] cap_addr = '0;
    logic [BYTE_W-1:0] cap_fn = '0;
    logic [BYTE_W-1:0] cap_d0 = '0;
    logic [BYTE_W-1:0] cap_d1 = '0;

    cfd_result_t expected_frames[$];
    logic [BYTE_W-1:0] pending_bytes[$];

    bit rx_taken;
    bit jitter;
    int mismatch_count;
    int bytes_accepted;
    int frame_bytes_queued;
    int frames_checked;
    int settings_run;
    int status_seen[4];
    int idle_cycles;

    task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        case (idx)
            REG_SOF_BYTE:           cfg_start = val;
            REG_EOF_BYTE:           cfg_end = val;
            REG_SPEED_FUNCTION:     cfg_speed_fn = val;
            REG_DIRECTION_FUNCTION: cfg_dir_fn = val;
            default:                ; // drop writes to unmapped indexes
        endcase
    endtask

    // Close the current frame and queue the word it must produce.
    task automatic close_frame(input logic [STATUS_W-1:0] st, input int unsigned len);
        cfd_result_t r;
        r = '0;
        r.status = st;
        r.frame_type = cap_type;
        r.device_addr = cap_addr;
        r.function_code = cap_fn;
        // Only ok and checksum-mismatch frames report a length
        if (st == ST_OK || st == ST_SUM)
            r.data_length = DATA_LEN_W'(len - MIN_FRAME);
        if (st == ST_OK)
        begin
            if (cap_fn == cfg_speed_fn)
                r.speed = cap_d0;
            if (cap_fn == cfg_dir_fn)
                r.degree = {cap_d0, cap_d1};
        end
        expected_frames.push_back(r);
        in_frame = 1'b0;
        next_pos = 0;
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        int unsigned pos;
        if (!in_frame)
        begin
            // Hunting: drop everything but the start code
            if (b == cfg_start)
            begin
                in_frame = 1'b1;
                next_pos = 1;
                sum_acc = '0;
                dly_old = '0;
                dly_new = '0;
                cap_type = '0;
                cap_addr = '0;
                cap_fn = '0;
                cap_d0 = '0;
                cap_d1 = '0;
                // Start code that is also the end code closes at once
                if (b == cfg_end)
                    close_frame(ST_SHORT, 1);
            end
        end
        else
        begin
            pos = next_pos;
            if (b == cfg_end)
            begin
                if (pos + 1 < MIN_FRAME)
                    close_frame(ST_SHORT, pos + 1);
                else
                    close_frame(({dly_old, dly_new} == sum_acc) ? ST_OK : ST_SUM, pos + 1);
            end
            else
            begin
                // The two newest bytes sit in the delay line until the end code
                // shows they were not the checksum.
                sum_acc = sum_acc + SUM_W'(dly_old);
                dly_old = dly_new;
                dly_new = b;
                case (pos)
                    1: cap_type = b;
                    2: cap_addr = b;
                    3: cap_fn = b;
                    4: cap_d0 = b;
                    5: cap_d1 = b;
                    default: ;
                endcase
                if (pos >= FRAME_CAPACITY - 1)
                    close_frame(ST_OVER, 0);
                else
                    next_pos = pos + 1;
            end
        end
    endtask

    task automatic check_frame(input cfd_result_t exp, input cfd_result_t got);
        if (got.status !== exp.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
            mismatch_count++;
        end
        if (got.frame_type !== exp.frame_type)
        begin
            $display("%0t: frame_type expected %0h actual %0h", $time, exp.frame_type,
                     got.frame_type);
            mismatch_count++;
        end
        if (got.device_addr !== exp.device_addr)
        begin
            $display("%0t: device_addr expected %0h actual %0h", $time, exp.device_addr,
                     got.device_addr);
            mismatch_count++;
        end
        if (got.function_code !== exp.function_code)
        begin
            $display("%0t: function_code expected %0h actual %0h", $time, exp.function_code,
                     got.function_code);
            mismatch_count++;
        end
        if (got.data_length !== exp.data_length)
        begin
            $display("%0t: data_length expected %0d actual %0d", $time, exp.data_length,
                     got.data_length);
            mismatch_count++;
        end
        if (got.speed !== exp.speed)
        begin
            $display("%0t: speed expected %0h actual %0h", $time, exp.speed, got.speed);
            mismatch_count++;
        end
        if (got.degree !== exp.degree)
        begin
            $display("%0t: degree expected %0h actual %0h", $time, exp.degree, got.degree);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Byte driver: advance at the falling edge, one word per handshake
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            rx_bus.valid <= 1'b0;
        else if (!rx_bus.valid || rx_taken)
        begin
            // Current word is gone (or none was offered): offer the next one,
            // or idle.
            if (pending_bytes.size() != 0 && (!jitter || $urandom_range(99) >= 34))
            begin
                rx_bus.valid <= 1'b1;
                rx_bus.rx_byte <= pending_bytes.pop_front();
            end
            else
                rx_bus.valid <= 1'b0;
        end
    end

    // Frame receiver: stall at random unless the phase runs steady
    always @(negedge clk)
    begin
        if (!rst_n)
            frame_bus.ready <= 1'b0;
        else
            frame_bus.ready <= !jitter || ($urandom_range(99) >= 34);
    end

    // ------------------------------------------------------------------
    // Monitor: sample every channel at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cfd_result_t got;
        cfd_result_t exp;
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            rx_taken = rx_bus.valid && rx_bus.ready;
            if (rx_taken)
            begin
                deframe_byte(rx_bus.rx_byte);
                bytes_accepted++;
                moved = 1'b1;
            end
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                apply_reg(cfg_bus.index, cfg_bus.data);
                moved = 1'b1;
            end
            if (frame_bus.valid && frame_bus.ready)
            begin
                moved = 1'b1;
                got.status = frame_bus.status;
                got.frame_type = frame_bus.frame_type;
                got.device_addr = frame_bus.device_addr;
                got.function_code = frame_bus.function_code;
                got.data_length = frame_bus.data_length;
                got.speed = frame_bus.speed;
                got.degree = frame_bus.degree;
                if (expected_frames.size() == 0)
                begin
                    $display("%0t: unexpected frame word, expected none actual status %0d",
                             $time, got.status);
                    mismatch_count++;
                end
                else
                begin
                    exp = expected_frames.pop_front();
                    check_frame(exp, got);
                    status_seen[exp.status]++;
                    frames_checked++;
                end
            end
            // Watchdog on cycles with nothing accepted anywhere
            if (moved)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d frame words outstanding",
                         $time, WATCHDOG_LIMIT, expected_frames.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        pending_bytes.push_back(b);
        frame_bytes_queued++;
    endtask

    // Random frame byte that never closes the frame; extremes are favored.
    function automatic logic [BYTE_W-1:0] pick_byte();
        logic [BYTE_W-1:0] b;
        do
        begin
            case ($urandom_range(7))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom);
            endcase
        end
        while (b == cfg_end);
        return b;
    endfunction

    // Byte the block ignores while hunting.
    function automatic logic [BYTE_W-1:0] hunt_noise();
        logic [BYTE_W-1:0] b;
        do
            b = 8'($urandom);
        while (b == cfg_start);
        return b;
    endfunction

    // Whole frame: start, header, payload, 16-bit sum high byte first, end.
    task automatic queue_frame(input logic [BYTE_W-1:0] ftype, input logic [BYTE_W-1:0] faddr,
                               input logic [BYTE_W-1:0] fn, input logic [BYTE_W-1:0] payload[$],
                               input bit corrupt);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(ftype) + SUM_W'(faddr) + SUM_W'(fn);
        foreach (payload[i])
            sum = sum + SUM_W'(payload[i]);
        if (corrupt)
            sum = sum ^ (SUM_W'(1) << $urandom_range(SUM_W - 1));
        send_byte(cfg_start);
        send_byte(ftype);
        send_byte(faddr);
        send_byte(fn);
        foreach (payload[i])
            send_byte(payload[i]);
        send_byte(sum[15:8]);
        send_byte(sum[7:0]);
        send_byte(cfg_end);
    endtask

    task automatic queue_random_frame();
        logic [BYTE_W-1:0] payload[$];
        logic [BYTE_W-1:0] fn;
        int n_data;
        int pick;
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0:       fn = cfg_speed_fn;
            1:       fn = cfg_dir_fn;
            default: fn = pick_byte();
        endcase
        if (fn == cfg_end)
            fn = pick_byte();
        // Mostly short payloads, now and then up to the full capacity
        n_data = ($urandom_range(9) == 0) ? $urandom_range(MAX_PAYLOAD) : $urandom_range(6);
        repeat (n_data)
            payload.push_back(pick_byte());
        if (pick < 55)
            queue_frame(pick_byte(), pick_byte(), fn, payload, 1'b0);
        else if (pick < 70)
            queue_frame(pick_byte(), pick_byte(), fn, payload, 1'b1);
        else if (pick < 80)
        begin
            // Start code buried in the payload is an ordinary byte
            if (cfg_start != cfg_end)
                payload.insert($urandom_range(payload.size()), cfg_start);
            if (payload.size() > MAX_PAYLOAD)
                payload.pop_back();
            queue_frame(pick_byte(), pick_byte(), fn, payload, 1'b0);
        end
        else if (pick < 90)
        begin
            // End code too early
            send_byte(cfg_start);
            repeat ($urandom_range(4))
                send_byte(pick_byte());
            send_byte(cfg_end);
        end
        else if (pick < 95)
        begin
            // No end code before the buffer fills
            send_byte(cfg_start);
            repeat (FRAME_CAPACITY - 1 + $urandom_range(2))
                send_byte(pick_byte());
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                send_byte(8'($urandom));
        end
        // Line noise between frames, ignored by the hunter
        if ($urandom_range(2) == 0)
            repeat ($urandom_range(1, 3))
                pending_bytes.push_back(hunt_noise());
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                                  input logic [BYTE_W-1:0] spd, input logic [BYTE_W-1:0] dir);
        write_reg(REG_SOF_BYTE, s);
        write_reg(REG_EOF_BYTE, e);
        write_reg(REG_SPEED_FUNCTION, spd);
        write_reg(REG_DIRECTION_FUNCTION, dir);
        // A write nobody decodes must leave the settings alone
        write_reg(CFG_INDEX_W'($urandom_range(FIRST_FREE_INDEX, 255)), 8'($urandom));
        settings_run++;
    endtask

    // Hold the sender until every word is out and every frame word is back.
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || rx_bus.valid || expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic run_phase(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                             input logic [BYTE_W-1:0] spd, input logic [BYTE_W-1:0] dir,
                             input bit steady, input int quota);
        int target;
        write_all_regs(s, e, spd, dir);
        jitter = !steady;
        target = frame_bytes_queued + quota;
        while (frame_bytes_queued < target)
            queue_random_frame();
        wait_idle();
    endtask

    function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        do
            r = 8'($urandom);
        while (r == b);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [BYTE_W-1:0] no_data[$];
        logic [BYTE_W-1:0] two_data[$];
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] spd;

        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        jitter = 1'b1;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: defaults written back explicitly, plus an unmapped write
        write_all_regs(SOF_BYTE_RESET, EOF_BYTE_RESET, SPEED_FUNCTION_RESET,
                       DIRECTION_FUNCTION_RESET);
        write_reg(REG_UNMAPPED, 8'h00);
        // Empty payload: speed comes from the checksum high byte
        queue_frame(8'h10, 8'h20, SPEED_FUNCTION_RESET, no_data, 1'b0);
        // Extreme header bytes, degree from two data bytes
        two_data.push_back(8'h12);
        two_data.push_back(8'h34);
        queue_frame(8'hFF, 8'h00, DIRECTION_FUNCTION_RESET, two_data, 1'b0);
        // Too short
        send_byte(SOF_BYTE_RESET);
        send_byte(8'h07);
        send_byte(EOF_BYTE_RESET);
        // Checksum off by one bit
        queue_frame(8'h00, 8'hFF, 8'h80, no_data, 1'b1);
        wait_idle();

        // Start code equal to end code: each opening byte is a short frame
        write_all_regs(8'h3C, 8'h3C, SPEED_FUNCTION_RESET, DIRECTION_FUNCTION_RESET);
        repeat (12)
        begin
            repeat ($urandom_range(3))
                pending_bytes.push_back(hunt_noise());
            send_byte(8'h3C);
        end
        wait_idle();

        // Random phases: defaults, both extremes, shared function code, random
        run_phase(SOF_BYTE_RESET, EOF_BYTE_RESET, SPEED_FUNCTION_RESET,
                  DIRECTION_FUNCTION_RESET, 1'b0, 220);
        run_phase(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0, 220);
        run_phase(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0, 220);
        s = 8'($urandom);
        spd = 8'($urandom);
        // Steady stretch: no idling on either side
        run_phase(s, other_than(s), spd, spd, 1'b1, 220);
        s = 8'($urandom);
        run_phase(s, other_than(s), 8'($urandom), 8'($urandom), 1'b0, 220);
        s = 8'($urandom);
        run_phase(s, other_than(s), 8'($urandom), 8'($urandom), 1'b0, 180);

        $display("Fed %0d bytes under %0d register settings; checked %0d frame words",
                 bytes_accepted, settings_run, frames_checked);
        $display("Status mix: %0d ok, %0d checksum, %0d overflow, %0d short",
                 status_seen[ST_OK], status_seen[ST_SUM], status_seen[ST_OVER],
                 status_seen[ST_SHORT]);
        if (mismatch_count == 0 && expected_frames.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
